// ===== design/oaids_pkg.sv =====
// Shared types, codes and width helpers for the ordered word list block.
// Used by oaids_ram, oaids_ctrl and ordered_array_insert_delete_search.
// Has no dependencies of its own.
package oaids_pkg;

  // Default number of word slots in the list.
  localparam int unsigned CAPACITY_DEF = 256;

  // Fixed field widths of the stream items.
  localparam int unsigned POS_W   = 9;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FOUND_W = 8;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 3;

  // Action codes carried in the input word.
  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_SEARCH = 3'd4
  } act_e;

  // Status codes returned with each result word.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_SRCH,
    S_HOLD
  } state_e;

  // One result word.
  typedef struct packed {
    logic [TOTAL_W-1:0]       element_total;
    logic [FOUND_W-1:0]       found_position;
    logic signed [WORD_W-1:0] read_value;
    status_e                  status;
  } res_t;

  // Address width of a store with cap entries, at least one bit.
  function automatic int unsigned addr_w(int unsigned cap);
    return (cap > 1) ? $clog2(cap) : 1;
  endfunction

  // Width of a counter that holds 0 .. cap.
  function automatic int unsigned cnt_w(int unsigned cap);
    return $clog2(cap + 1);
  endfunction

endpackage

// ===== design/oaids_ram.sv =====
// Word store of the list: one write port and one registered read port.
// Depends on oaids_pkg for the word width and the address width helper.
module oaids_ram #(
  parameter  int unsigned CAPACITY = oaids_pkg::CAPACITY_DEF,
  localparam int unsigned AW       = oaids_pkg::addr_w(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [oaids_pkg::WORD_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [oaids_pkg::WORD_W-1:0]  rdata_o
);
  import oaids_pkg::*;

  logic [WORD_W-1:0] mem_q [CAPACITY];
  logic [WORD_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port: the addressed word appears in the cycle after re_i.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/oaids_ctrl.sv =====
// Sequencer of the list: checks each action, walks the store for shifts and
// searches, keeps the word count and holds the result word for the receiver.
// Depends on oaids_pkg; drives the ports of oaids_ram.
module oaids_ctrl #(
  parameter  int unsigned CAPACITY = oaids_pkg::CAPACITY_DEF,
  localparam int unsigned AW       = oaids_pkg::addr_w(CAPACITY)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  oaids_pkg::act_e                     in_action_i,
  input  logic [oaids_pkg::POS_W-1:0]         in_position_i,
  input  logic signed [oaids_pkg::WORD_W-1:0] in_operand_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output oaids_pkg::res_t                     out_res_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [oaids_pkg::WORD_W-1:0]        mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  logic [oaids_pkg::WORD_W-1:0]        mem_rdata_i
);
  import oaids_pkg::*;

  localparam int unsigned CW = cnt_w(CAPACITY);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [WORD_W-1:0]  val_q, val_d;
  res_t               res_q, res_d;
  logic               ovalid_q, ovalid_d;
  res_t               odata_q, odata_d;

  logic [XW-1:0]      pos_x, cnt_x, ptr_x, cntd_x;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      pos_a, last_idx;
  logic               empty, full, out_free, oload;
  logic               fin;
  status_e            fin_st;
  logic [WORD_W-1:0]  fin_rd;
  logic               fin_found;
  res_t               fin_res;

  // Index arithmetic shared by all actions.
  assign pos_x    = XW'(in_position_i);
  assign cnt_x    = XW'(count_q);
  assign ptr_x    = XW'(ptr_q);
  assign cntd_x   = XW'(count_d);
  assign pos_a    = pos_x[AW-1:0];
  assign cnt_m1   = count_q - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(CAPACITY));
  assign out_free = !ovalid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state, store accesses and result assembly.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    res_d       = res_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    fin         = 1'b0;
    fin_st      = ST_OK;
    fin_rd      = '0;
    fin_found   = 1'b0;
    oload       = 1'b0;
    odata_d     = odata_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d = pos_a;
          val_d = in_operand_i;
          unique case (in_action_i)
            ACT_READ: begin
              if (empty) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                fin    = 1'b1;
                fin_st = ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_a;
                state_d     = S_READ;
              end
            end
            ACT_WRITE: begin
              fin = 1'b1;
              if (empty) begin
                fin_st = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                fin_st = ST_RANGE;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = pos_a;
                mem_wdata_o = in_operand_i;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else if (pos_x > cnt_x) begin
                fin    = 1'b1;
                fin_st = ST_RANGE;
              end else if (pos_x == cnt_x) begin
                // Append at the end: no words to move.
                mem_we_o    = 1'b1;
                mem_waddr_o = pos_a;
                mem_wdata_o = in_operand_i;
                count_d     = count_q + CW'(1);
                fin         = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = last_idx;
                ptr_d       = last_idx;
                state_d     = S_INS;
              end
            end
            ACT_DELETE: begin
              if (empty) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                fin    = 1'b1;
                fin_st = ST_RANGE;
              end else if (pos_a == last_idx) begin
                // Removing the last word only shortens the list.
                count_d = count_q - CW'(1);
                fin     = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_a + AW'(1);
                ptr_d       = pos_a + AW'(1);
                state_d     = S_DEL;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                fin    = 1'b1;
                fin_st = ST_NOTFOUND;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                ptr_d       = '0;
                state_d     = S_SRCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        fin    = 1'b1;
        fin_rd = mem_rdata_i;
      end

      // Move words up one place, from the top down to the insert position.
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q + AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (ptr_q == pos_q) begin
          state_d = S_INS_LAST;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q - AW'(1);
          ptr_d       = ptr_q - AW'(1);
        end
      end

      S_INS_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        fin         = 1'b1;
      end

      // Move words down one place, from above the delete position upward.
      S_DEL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q - AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (ptr_q == last_idx) begin
          count_d = count_q - CW'(1);
          fin     = 1'b1;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + AW'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end

      // Compare one stored word a cycle against the key.
      S_SRCH: begin
        if (mem_rdata_i == val_q) begin
          fin       = 1'b1;
          fin_found = 1'b1;
        end else if (ptr_q == last_idx) begin
          fin    = 1'b1;
          fin_st = ST_NOTFOUND;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + AW'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end

      S_HOLD: begin
        if (out_free) begin
          oload   = 1'b1;
          odata_d = res_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Finished action: hand the result to the output register or park it.
    fin_res.status         = fin_st;
    fin_res.read_value     = fin_rd;
    fin_res.found_position = fin_found ? ptr_x[FOUND_W-1:0] : '0;
    fin_res.element_total  = cntd_x[TOTAL_W-1:0];
    if (fin) begin
      if (out_free) begin
        oload   = 1'b1;
        odata_d = fin_res;
        state_d = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_HOLD;
      end
    end

    ovalid_d = oload ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    res_q   <= res_d;
    odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_res_o   = odata_q;

endmodule

// ===== design/ordered_array_insert_delete_search.sv =====
// Ordered word list with read, write, insert, delete and linear search.
// Usage:
//   Each input word on the s_axis channel is one action; each action gives
//   exactly one result word on the m_axis channel, in order.
//   Writes, appends, tail deletes and rejected actions finish when taken;
//   a read passes S_READ, an insert walks S_INS per moved word and then
//   S_INS_LAST, a delete walks S_DEL per moved word and a search S_SRCH per
//   word compared; the result is then registered, or parked if the output is busy.
//   The rate is set by the single read port of the word store: shifts and
//   searches touch one stored word per cycle, up to CAPACITY per action.
//   One action is processed at a time; s_axis_tready is high while idle.
//   The result sits in an output register, so a new action is taken while
//   the previous result still waits. If the receiver stalls, a finished
//   result is parked and input is held off until the output register frees.
//   Reset empties the list (count zero) and drops any pending result; the
//   store contents are not cleared, as only words below the count are read.
// Depends on oaids_pkg, oaids_ram and oaids_ctrl.
module ordered_array_insert_delete_search #(
  parameter int unsigned CAPACITY = oaids_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action, [11:3] position, [43:12] operand_value, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [34:3] read_value, [42:35] found_position,
  // [51:43] element_total, [55:52] zero
  output logic [55:0] m_axis_tdata
);
  import oaids_pkg::*;

  localparam int unsigned AW = addr_w(CAPACITY);

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [WORD_W-1:0]        mem_wdata, mem_rdata;
  res_t                     res;
  act_e                     in_action;

  // Input word unpacking.
  assign in_action = act_e'(s_axis_tdata[2:0]);

  oaids_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (in_action),
    .in_position_i (s_axis_tdata[11:3]),
    .in_operand_i  (s_axis_tdata[43:12]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  oaids_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result word packing.
  assign m_axis_tdata = {4'b0000, res.element_total, res.found_position,
                         res.read_value, res.status};

endmodule
